FILE: rtl/sst_pkg.sv
// Shared widths, register indexes, reset values and types of the speed statistics tracker.
package sst_pkg;

    // Field widths.
    localparam int TIME_W       = 32;
    localparam int SPEED_W      = 24;
    localparam int SPEED_MAG_W  = 23;
    localparam int ANG_W        = 32;
    localparam int ACCEL_W      = 32;
    localparam int PEAK_ACCEL_W = 31;
    localparam int INTERVAL_W   = 16;
    localparam int MOVE_LIMIT_W = 31;

    // Configuration port.
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 32;

    // Divider operands: a signed speed difference times 1000 needs 35 bits.
    localparam int DIV_NUM_W = 35;
    localparam int DIV_DEN_W = 32;

    // Speeds and accelerations share 16 fraction bits, so the scale is ms per second.
    localparam int MS_PER_S = 1000;

    // Register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_REPORT_INTERVAL = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED_EPSILON   = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_STANDSTILL      = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_MOVING_LIMIT    = CFG_ADDR_W'(3);

    // Configuration register set.
    typedef struct packed {
        logic [INTERVAL_W-1:0]   report_interval_ms;
        logic [SPEED_MAG_W-1:0]  speed_epsilon;
        logic [SPEED_MAG_W-1:0]  standstill_limit;
        logic [MOVE_LIMIT_W-1:0] moving_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        report_interval_ms: INTERVAL_W'(10),
        speed_epsilon:      SPEED_MAG_W'(655),
        standstill_limit:   SPEED_MAG_W'(66),
        moving_limit:       MOVE_LIMIT_W'(168)
    };

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_EVAL,
        ST_TOP,
        ST_RUN,
        ST_WAIT,
        ST_PEAK,
        ST_OUT
    } sst_state_t;

endpackage

FILE: rtl/sst_if.sv
// Handshake interfaces for the sample, report and configuration channels.
interface sst_sample_if;
    import sst_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [TIME_W-1:0]         time_ms;
    logic signed [SPEED_W-1:0] speed_sample;
    logic signed [ANG_W-1:0]   angular_sample;

    modport source (output valid, time_ms, speed_sample, angular_sample, input ready);
    modport sink   (input valid, time_ms, speed_sample, angular_sample, output ready);
endinterface

interface sst_report_if;
    import sst_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] speed_out;
    logic signed [ACCEL_W-1:0] accel_out;
    logic [SPEED_MAG_W-1:0]    peak_speed;
    logic [TIME_W-1:0]         time_to_top_ms;
    logic signed [ACCEL_W-1:0] run_accel;
    logic [PEAK_ACCEL_W-1:0]   peak_accel;
    logic [TIME_W-1:0]         moving_time_ms;
    logic                      is_moving;

    modport source (output valid, speed_out, accel_out, peak_speed, time_to_top_ms,
                    run_accel, peak_accel, moving_time_ms, is_moving, input ready);
    modport sink   (input valid, speed_out, accel_out, peak_speed, time_to_top_ms,
                    run_accel, peak_accel, moving_time_ms, is_moving, output ready);
endinterface

interface sst_cfg_if;
    import sst_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

FILE: rtl/speed_statistics_tracker.sv
// Speed statistics tracker: interval-gated reports of speed, acceleration and run statistics.
// A sample with no report passes ST_PREP and ST_EVAL; the block then takes the next word.
// A reporting sample goes on through ST_TOP, ST_RUN, ST_WAIT, ST_PEAK and ST_OUT, where its
// report is loaded before the next word; ST_WAIT waits for the 34-step bit-serial dividers.
// A stalled report output holds the next report in its final state until the register frees.
// rst_n (asynchronous) clears all statistics to zero and loads the register defaults.
module speed_statistics_tracker (
    input  logic          clk,
    input  logic          rst_n,
    sst_cfg_if.sink       cfg,
    sst_sample_if.sink    samples,
    sst_report_if.source  reports
);
    import sst_pkg::*;

    localparam logic signed [DIV_NUM_W-1:0] MS_SCALE = DIV_NUM_W'(MS_PER_S);

    cfg_t cfg_regs;

    sst_state_t state_reg, state_next;

    // Sample under work and intermediate results.
    logic [TIME_W-1:0]           t_reg, t_next;
    logic signed [SPEED_W-1:0]   s_reg, s_next;
    logic signed [ANG_W-1:0]     a_reg, a_next;
    logic [TIME_W-1:0]           elapsed_reg, elapsed_next;
    logic [SPEED_W-1:0]          mag_reg, mag_next;
    logic [ANG_W-1:0]            amag_reg, amag_next;
    logic signed [SPEED_W:0]     delta_reg, delta_next;
    logic signed [DIV_NUM_W-1:0] run_num_reg, run_num_next;
    logic signed [DIV_NUM_W-1:0] accel_num_reg, accel_num_next;
    logic                        new_top_reg, new_top_next;
    logic                        moving_reg, moving_next;
    logic signed [SPEED_W:0]     top_diff_reg, top_diff_next;
    logic                        s_pos_reg, s_pos_next;
    logic                        run_pending_reg, run_pending_next;
    logic signed [ACCEL_W-1:0]   accel_reg, accel_next;
    logic [TIME_W-1:0]           moving_time_reg, moving_time_next;

    // Statistics kept between reports.
    logic [TIME_W-1:0]         last_report_time_reg, last_report_time_next;
    logic signed [SPEED_W-1:0] last_speed_reg, last_speed_next;
    logic [SPEED_MAG_W-1:0]    top_speed_reg, top_speed_next;
    logic [TIME_W-1:0]         standstill_time_reg, standstill_time_next;
    logic                      was_standstill_reg, was_standstill_next;
    logic                      was_top_reg, was_top_next;
    logic [TIME_W-1:0]         top_time_reg, top_time_next;
    logic signed [ACCEL_W-1:0] top_run_accel_reg, top_run_accel_next;
    logic [PEAK_ACCEL_W-1:0]   top_accel_reg, top_accel_next;
    logic                      was_rot_still_reg, was_rot_still_next;
    logic [TIME_W-1:0]         rot_still_time_reg, rot_still_time_next;

    // Report output register.
    logic                      out_valid_reg, out_valid_next;
    logic signed [SPEED_W-1:0] out_speed_reg, out_speed_next;
    logic signed [ACCEL_W-1:0] out_accel_reg, out_accel_next;
    logic [SPEED_MAG_W-1:0]    out_peak_speed_reg, out_peak_speed_next;
    logic [TIME_W-1:0]         out_top_time_reg, out_top_time_next;
    logic signed [ACCEL_W-1:0] out_run_accel_reg, out_run_accel_next;
    logic [PEAK_ACCEL_W-1:0]   out_peak_accel_reg, out_peak_accel_next;
    logic [TIME_W-1:0]         out_moving_time_reg, out_moving_time_next;
    logic                      out_moving_reg, out_moving_next;

    // Divider handshake.
    logic                      accel_start, run_start;
    logic                      accel_busy, run_busy;
    logic signed [ACCEL_W-1:0] accel_quot, run_quot;
    logic [TIME_W-1:0]         run_den;

    sst_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    // Acceleration since the last report: 1000 * speed change / elapsed ms.
    sst_serial_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W),
        .OUT_W (ACCEL_W)
    ) u_accel_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accel_start),
        .num   (accel_num_reg),
        .den   (elapsed_reg),
        .busy  (accel_busy),
        .quot  (accel_quot)
    );

    // Acceleration over the run from standstill to top speed.
    sst_serial_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W),
        .OUT_W (ACCEL_W)
    ) u_run_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (run_start),
        .num   (run_num_reg),
        .den   (run_den),
        .busy  (run_busy),
        .quot  (run_quot)
    );

    assign run_den = t_reg - standstill_time_reg;

    assign samples.ready          = (state_reg == ST_IDLE);
    assign reports.valid          = out_valid_reg;
    assign reports.speed_out      = out_speed_reg;
    assign reports.accel_out      = out_accel_reg;
    assign reports.peak_speed     = out_peak_speed_reg;
    assign reports.time_to_top_ms = out_top_time_reg;
    assign reports.run_accel      = out_run_accel_reg;
    assign reports.peak_accel     = out_peak_accel_reg;
    assign reports.moving_time_ms = out_moving_time_reg;
    assign reports.is_moving      = out_moving_reg;

    // Sequencer: steps through the sample's arithmetic, then runs the two divisions in parallel.
    always_comb
    begin : seq_logic
        logic                     report_due;
        logic [SPEED_W:0]         top_limit;
        logic                     new_top;
        logic signed [SPEED_W:0]  eps_pos;
        logic signed [SPEED_W:0]  eps_neg;
        logic                     at_top;
        logic                     run_fire;
        logic [ACCEL_W-1:0]       accel_limit;
        logic                     out_free;

        state_next       = state_reg;
        t_next           = t_reg;
        s_next           = s_reg;
        a_next           = a_reg;
        elapsed_next     = elapsed_reg;
        mag_next         = mag_reg;
        amag_next        = amag_reg;
        delta_next       = delta_reg;
        run_num_next     = run_num_reg;
        accel_num_next   = accel_num_reg;
        new_top_next     = new_top_reg;
        moving_next      = moving_reg;
        top_diff_next    = top_diff_reg;
        s_pos_next       = s_pos_reg;
        run_pending_next = run_pending_reg;
        accel_next       = accel_reg;
        moving_time_next = moving_time_reg;

        last_report_time_next = last_report_time_reg;
        last_speed_next       = last_speed_reg;
        top_speed_next        = top_speed_reg;
        standstill_time_next  = standstill_time_reg;
        was_standstill_next   = was_standstill_reg;
        was_top_next          = was_top_reg;
        top_time_next         = top_time_reg;
        top_run_accel_next    = top_run_accel_reg;
        top_accel_next        = top_accel_reg;
        was_rot_still_next    = was_rot_still_reg;
        rot_still_time_next   = rot_still_time_reg;

        out_speed_next       = out_speed_reg;
        out_accel_next       = out_accel_reg;
        out_peak_speed_next  = out_peak_speed_reg;
        out_top_time_next    = out_top_time_reg;
        out_run_accel_next   = out_run_accel_reg;
        out_peak_accel_next  = out_peak_accel_reg;
        out_moving_time_next = out_moving_time_reg;
        out_moving_next      = out_moving_reg;

        accel_start = 1'b0;
        run_start   = 1'b0;

        report_due  = (elapsed_reg > TIME_W'(cfg_regs.report_interval_ms));
        top_limit   = {2'b00, top_speed_reg} + {2'b00, cfg_regs.speed_epsilon};
        new_top     = ({1'b0, mag_reg} > top_limit);
        eps_pos     = $signed({2'b00, cfg_regs.speed_epsilon});
        eps_neg     = -eps_pos;
        at_top      = (top_diff_reg < eps_pos) && (top_diff_reg > eps_neg) && s_pos_reg;
        run_fire    = new_top_reg || (at_top && !was_top_reg && was_standstill_reg);
        accel_limit = {1'b0, top_accel_reg} + ACCEL_W'(cfg_regs.speed_epsilon);

        // The output register frees when it is empty or its word leaves now.
        out_free       = !out_valid_reg || reports.ready;
        out_valid_next = out_valid_reg && !reports.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (samples.valid)
                begin
                    t_next     = samples.time_ms;
                    s_next     = samples.speed_sample;
                    a_next     = samples.angular_sample;
                    state_next = ST_PREP;
                end
            end

            // Elapsed time, magnitudes, speed change and the run numerator.
            ST_PREP:
            begin
                elapsed_next = t_reg - last_report_time_reg;
                mag_next     = s_reg[SPEED_W-1] ? (~s_reg + 1'b1) : s_reg;
                amag_next    = a_reg[ANG_W-1] ? (~a_reg + 1'b1) : a_reg;
                delta_next   = {s_reg[SPEED_W-1], s_reg}
                             - {last_speed_reg[SPEED_W-1], last_speed_reg};
                run_num_next = DIV_NUM_W'(s_reg) * MS_SCALE;
                state_next   = ST_EVAL;
            end

            // Interval gate, top speed, standstill and rotation tests.
            ST_EVAL:
            begin
                if (!report_due)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    new_top_next = new_top;
                    if (new_top)
                    begin
                        top_speed_next = mag_reg[SPEED_W-1] ? {SPEED_MAG_W{1'b1}}
                                                            : mag_reg[SPEED_MAG_W-1:0];
                    end
                    if (mag_reg < {1'b0, cfg_regs.standstill_limit})
                    begin
                        standstill_time_next = t_reg;
                        was_standstill_next  = 1'b1;
                    end
                    moving_next    = (amag_reg > {1'b0, cfg_regs.moving_limit});
                    accel_num_next = DIV_NUM_W'(delta_reg) * MS_SCALE;
                    state_next     = ST_TOP;
                end
            end

            // Distance from the updated top speed; launch the acceleration division.
            ST_TOP:
            begin
                top_diff_next = {s_reg[SPEED_W-1], s_reg} - {2'b00, top_speed_reg};
                s_pos_next    = $signed({s_reg[SPEED_W-1], s_reg}) > eps_pos;
                accel_start   = 1'b1;
                state_next    = ST_RUN;
            end

            // New or reached top speed: record the run and launch its division; track the moving time.
            ST_RUN:
            begin
                was_top_next     = at_top;
                run_pending_next = run_fire;
                if (run_fire)
                begin
                    top_time_next       = run_den;
                    run_start           = 1'b1;
                    was_standstill_next = 1'b0;
                end
                if (moving_reg)
                begin
                    if (was_rot_still_reg)
                    begin
                        rot_still_time_next = t_reg;
                        was_rot_still_next  = 1'b0;
                        moving_time_next    = '0;
                    end
                    else
                    begin
                        moving_time_next = t_reg - rot_still_time_reg;
                    end
                end
                else
                begin
                    was_rot_still_next = 1'b1;
                    moving_time_next   = '0;
                end
                state_next = ST_WAIT;
            end

            ST_WAIT:
            begin
                if (!accel_busy && !run_busy)
                begin
                    accel_next = accel_quot;
                    if (run_pending_reg)
                    begin
                        top_run_accel_next = run_quot;
                    end
                    state_next = ST_PEAK;
                end
            end

            // Peak positive acceleration with tolerance.
            ST_PEAK:
            begin
                if (!accel_reg[ACCEL_W-1] && accel_reg != '0
                    && {1'b0, accel_reg[PEAK_ACCEL_W-1:0]} > accel_limit)
                begin
                    top_accel_next = accel_reg[PEAK_ACCEL_W-1:0];
                end
                state_next = ST_OUT;
            end

            // Load the report word once the output register is free.
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_speed_next        = s_reg;
                    out_accel_next        = accel_reg;
                    out_peak_speed_next   = top_speed_reg;
                    out_top_time_next     = top_time_reg;
                    out_run_accel_next    = top_run_accel_reg;
                    out_peak_accel_next   = top_accel_reg;
                    out_moving_time_next  = moving_time_reg;
                    out_moving_next       = moving_reg;
                    last_speed_next       = s_reg;
                    last_report_time_next = t_reg;
                    state_next            = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Statistics and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_report_time_reg <= '0;
            last_speed_reg       <= '0;
            top_speed_reg        <= '0;
            standstill_time_reg  <= '0;
            was_standstill_reg   <= 1'b0;
            was_top_reg          <= 1'b0;
            top_time_reg         <= '0;
            top_run_accel_reg    <= '0;
            top_accel_reg        <= '0;
            was_rot_still_reg    <= 1'b0;
            rot_still_time_reg   <= '0;
            run_pending_reg      <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            last_report_time_reg <= last_report_time_next;
            last_speed_reg       <= last_speed_next;
            top_speed_reg        <= top_speed_next;
            standstill_time_reg  <= standstill_time_next;
            was_standstill_reg   <= was_standstill_next;
            was_top_reg          <= was_top_next;
            top_time_reg         <= top_time_next;
            top_run_accel_reg    <= top_run_accel_next;
            top_accel_reg        <= top_accel_next;
            was_rot_still_reg    <= was_rot_still_next;
            rot_still_time_reg   <= rot_still_time_next;
            run_pending_reg      <= run_pending_next;
            out_valid_reg        <= out_valid_next;
        end
    end

    // Working registers and report payload.
    always_ff @(posedge clk)
    begin
        t_reg               <= t_next;
        s_reg               <= s_next;
        a_reg               <= a_next;
        elapsed_reg         <= elapsed_next;
        mag_reg             <= mag_next;
        amag_reg            <= amag_next;
        delta_reg           <= delta_next;
        run_num_reg         <= run_num_next;
        accel_num_reg       <= accel_num_next;
        new_top_reg         <= new_top_next;
        moving_reg          <= moving_next;
        top_diff_reg        <= top_diff_next;
        s_pos_reg           <= s_pos_next;
        accel_reg           <= accel_next;
        moving_time_reg     <= moving_time_next;
        out_speed_reg       <= out_speed_next;
        out_accel_reg       <= out_accel_next;
        out_peak_speed_reg  <= out_peak_speed_next;
        out_top_time_reg    <= out_top_time_next;
        out_run_accel_reg   <= out_run_accel_next;
        out_peak_accel_reg  <= out_peak_accel_next;
        out_moving_time_reg <= out_moving_time_next;
        out_moving_reg      <= out_moving_next;
    end

    // Both quotients are final before the peak test reads them.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PEAK |-> !accel_busy && !run_busy)
        else $error("peak test reached with a division still running");

    // The recorded top speed never falls.
    assert property (@(posedge clk) disable iff (!rst_n)
        top_speed_reg >= $past(top_speed_reg))
        else $error("top speed decreased");

    // A report that is not moving carries no moving time.
    assert property (@(posedge clk) disable iff (!rst_n)
        reports.valid && !reports.is_moving |-> reports.moving_time_ms == '0)
        else $error("moving time without motion");

endmodule

FILE: rtl/sst_cfg_regs.sv
// Configuration register file of the speed statistics tracker.
module sst_cfg_regs (
    input  logic        clk,
    input  logic        rst_n,
    sst_cfg_if.sink     cfg,
    output sst_pkg::cfg_t regs
);
    import sst_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    // The port never stalls a write.
    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Decode the write word; unknown indexes are dropped.
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.addr)
                REG_REPORT_INTERVAL: regs_next.report_interval_ms = cfg.data[INTERVAL_W-1:0];
                REG_SPEED_EPSILON:   regs_next.speed_epsilon      = cfg.data[SPEED_MAG_W-1:0];
                REG_STANDSTILL:      regs_next.standstill_limit   = cfg.data[SPEED_MAG_W-1:0];
                REG_MOVING_LIMIT:    regs_next.moving_limit       = cfg.data[MOVE_LIMIT_W-1:0];
                default:             regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= CFG_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

FILE: rtl/sst_serial_div.sv
// Bit-serial signed-by-unsigned divider with truncation toward zero and saturation.
module sst_serial_div #(
    parameter int NUM_W = sst_pkg::DIV_NUM_W,
    parameter int DEN_W = sst_pkg::DIV_DEN_W,
    parameter int OUT_W = sst_pkg::ACCEL_W
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic                    busy,
    output logic signed [OUT_W-1:0] quot
);
    localparam int MAG_W = NUM_W - 1;
    localparam int CNT_W = $clog2(MAG_W + 1);

    localparam logic [MAG_W-1:0] POS_LIMIT =
        {{(MAG_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
    localparam logic [MAG_W-1:0] NEG_LIMIT =
        {{(MAG_W - OUT_W){1'b0}}, 1'b1, {(OUT_W - 1){1'b0}}};
    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

    logic             active_reg, active_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0] shift_reg, shift_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;
    logic             zero_reg, zero_next;

    assign busy = active_reg;

    // One quotient bit per cycle: the numerator shifts out at the top while
    // quotient bits shift in at the bottom.
    always_comb
    begin : step_logic
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [NUM_W-1:0] num_abs;

        active_next = active_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        shift_next  = shift_reg;
        den_next    = den_reg;
        neg_next    = neg_reg;
        zero_next   = zero_reg;

        trial   = {rem_reg, shift_reg[MAG_W-1]};
        diff    = trial - {1'b0, den_reg};
        ge      = (trial >= {1'b0, den_reg});
        num_abs = num[NUM_W-1] ? (~num + 1'b1) : num;

        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = CNT_W'(MAG_W);
            rem_next    = '0;
            shift_next  = num_abs[MAG_W-1:0];
            den_next    = den;
            neg_next    = num[NUM_W-1];
            zero_next   = (num == '0);
        end
        else if (active_reg)
        begin
            rem_next   = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            shift_next = {shift_reg[MAG_W-2:0], ge};
            cnt_next   = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                active_next = 1'b0;
            end
        end
    end

    // Apply the sign and clamp to the output range. A zero divisor gives an
    // all-ones magnitude, which clamps by sign; a zero numerator gives zero.
    always_comb
    begin
        if (zero_reg)
        begin
            quot = '0;
        end
        else if (neg_reg)
        begin
            quot = (shift_reg > NEG_LIMIT) ? OUT_MIN : (~shift_reg[OUT_W-1:0] + 1'b1);
        end
        else
        begin
            quot = (shift_reg > POS_LIMIT) ? OUT_MAX : shift_reg[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        den_reg   <= den_next;
        neg_reg   <= neg_next;
        zero_reg  <= zero_next;
    end

    // A new division never starts on top of a running one.
    assert property (@(posedge clk) disable iff (!rst_n) start |-> !active_reg)
        else $error("divider restarted while busy");

    // The step counter runs out exactly when the unit goes idle.
    assert property (@(posedge clk) disable iff (!rst_n) active_reg |-> cnt_reg != '0)
        else $error("divider active with spent counter");

    // The partial remainder stays below a nonzero divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg && den_reg != '0 |-> rem_reg < den_reg)
        else $error("divider remainder out of range");

endmodule

FILE: sim/speed_statistics_tracker_tb.sv
// Self-checking testbench for the speed statistics tracker: directed table, then random phases.
module speed_statistics_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    localparam int RESET_CYCLES    = 11;
    localparam int IDLE_PCT        = 18;
    localparam int QUIET_CYCLES    = 50;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int N_PHASES        = 5;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int HOLD_AFTER      = 150;
    localparam int HOLD_CYCLES     = 400;
    localparam int RAMP_STEP       = 1 << 16;

    localparam longint ACC_MAX  = 2147483647;
    localparam longint ACC_MIN  = -ACC_MAX - 1;
    localparam longint MAG_MAX  = (longint'(1) << SPEED_MAG_W) - 1;
    localparam longint SPEED_HI = (longint'(1) << (SPEED_W - 1)) - 1;
    localparam longint SPEED_LO = -SPEED_HI - 1;

    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 24'sh7FFFFF;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = 24'sh800000;
    localparam logic signed [ANG_W-1:0]   ANG_MAX   = 32'sh7FFFFFFF;
    localparam logic signed [ANG_W-1:0]   ANG_MIN   = 32'sh80000000;
    localparam logic [TIME_W-1:0]         TIME_MAX  = 32'hFFFFFFFF;

    // An index past the end of the register list; the block must ignore it.
    localparam logic [CFG_ADDR_W-1:0] REG_NONE = CFG_ADDR_W'(200);

    typedef enum logic [1:0] {
        EXP_PREDICT,
        EXP_SILENT,
        EXP_ZERO_REPORT
    } exp_kind_t;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        logic [TIME_W-1:0]         time_ms;
        logic signed [SPEED_W-1:0] speed;
        logic signed [ANG_W-1:0]   angular;
    } sample_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed_out;
        logic signed [ACCEL_W-1:0] accel_out;
        logic [SPEED_MAG_W-1:0]    peak_speed;
        logic [TIME_W-1:0]         time_to_top_ms;
        logic signed [ACCEL_W-1:0] run_accel;
        logic [PEAK_ACCEL_W-1:0]   peak_accel;
        logic [TIME_W-1:0]         moving_time_ms;
        logic                      is_moving;
    } report_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_ADDR_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        sample_t               smp;
        exp_kind_t             how;
    } step_row_t;

    logic clk;
    logic rst_n;
    logic calm;
    exp_kind_t item_how;
    int failures = 0;

    sst_cfg_if    cfg ();
    sst_sample_if samples ();
    sst_report_if reports ();

    speed_statistics_tracker uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .samples (samples),
        .reports (reports)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Predictor copy of the registers.
    logic [INTERVAL_W-1:0]   cfg_interval = CFG_RESET.report_interval_ms;
    logic [SPEED_MAG_W-1:0]  cfg_eps      = CFG_RESET.speed_epsilon;
    logic [SPEED_MAG_W-1:0]  cfg_still    = CFG_RESET.standstill_limit;
    logic [MOVE_LIMIT_W-1:0] cfg_spin     = CFG_RESET.moving_limit;

    // Predictor copy of the tracking state.
    logic [TIME_W-1:0] prev_report_t   = '0;
    longint            prev_speed      = 0;
    longint            best_speed      = 0;
    logic [TIME_W-1:0] still_t         = '0;
    bit                still_flag      = 1'b0;
    bit                top_flag        = 1'b0;
    logic [TIME_W-1:0] run_time        = '0;
    longint            run_accel_held  = 0;
    longint            best_accel      = 0;
    bit                spin_still_flag = 1'b0;
    logic [TIME_W-1:0] spin_start_t    = '0;

    report_t due_reports[$];

    // Quotient truncated toward zero and clamped to 32 bits; a zero divisor clamps by sign.
    function automatic longint clamp_div(input longint num, input logic [TIME_W-1:0] den);
        longint q;
        if (den == '0)
            return (num > 0) ? ACC_MAX : ((num < 0) ? ACC_MIN : 0);
        q = num / longint'(den);
        if (q > ACC_MAX)
            return ACC_MAX;
        if (q < ACC_MIN)
            return ACC_MIN;
        return q;
    endfunction

    // Advances the tracking state by one sample; returns 1 when the sample reports.
    function automatic bit track_sample(input sample_t smp, output report_t rep);
        longint s;
        longint a;
        longint mag;
        longint eps;
        longint gap;
        longint accel;
        logic [TIME_W-1:0] elapsed;
        bit new_top;
        bit at_top;
        bit just_top;
        bit moving;
        rep = '0;
        s = $signed(smp.speed);
        a = $signed(smp.angular);
        eps = longint'(cfg_eps);
        elapsed = smp.time_ms - prev_report_t;
        if (elapsed <= TIME_W'(cfg_interval))
            return 1'b0;

        // Peak speed and standstill tracking.
        mag = (s < 0) ? -s : s;
        new_top = mag > eps + best_speed;
        if (new_top)
            best_speed = (mag > MAG_MAX) ? MAG_MAX : mag;
        if (mag < longint'(cfg_still))
        begin
            still_t = smp.time_ms;
            still_flag = 1'b1;
        end

        // Run from standstill to top speed.
        gap = (s > best_speed) ? s - best_speed : best_speed - s;
        at_top = (gap < eps) && (s > eps);
        just_top = at_top && !top_flag;
        top_flag = at_top;
        if (new_top || (just_top && still_flag))
        begin
            run_time = smp.time_ms - still_t;
            run_accel_held = clamp_div(s * MS_PER_S, run_time);
            still_flag = 1'b0;
        end

        // Acceleration since the last report and its positive peak.
        accel = clamp_div((s - prev_speed) * MS_PER_S, elapsed);
        if (accel > 0 && accel > eps + best_accel)
            best_accel = accel;

        // Rotation.
        moving = ((a < 0) ? -a : a) > longint'(cfg_spin);
        if (moving)
        begin
            if (spin_still_flag)
            begin
                spin_start_t = smp.time_ms;
                spin_still_flag = 1'b0;
            end
            rep.moving_time_ms = smp.time_ms - spin_start_t;
        end
        else
            spin_still_flag = 1'b1;

        rep.speed_out      = smp.speed;
        rep.accel_out      = accel[ACCEL_W-1:0];
        rep.peak_speed     = best_speed[SPEED_MAG_W-1:0];
        rep.time_to_top_ms = run_time;
        rep.run_accel      = run_accel_held[ACCEL_W-1:0];
        rep.peak_accel     = best_accel[PEAK_ACCEL_W-1:0];
        rep.is_moving      = moving;
        prev_speed = s;
        prev_report_t = smp.time_ms;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // Register writes, report checks and predictions, all sampled at the clock edge.
    always @(posedge clk)
    begin : report_check
        report_t want;
        report_t got;
        report_t fresh;
        bit fires;
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.addr)
                    REG_REPORT_INTERVAL: cfg_interval = cfg.data[INTERVAL_W-1:0];
                    REG_SPEED_EPSILON:   cfg_eps      = cfg.data[SPEED_MAG_W-1:0];
                    REG_STANDSTILL:      cfg_still    = cfg.data[SPEED_MAG_W-1:0];
                    REG_MOVING_LIMIT:    cfg_spin     = cfg.data[MOVE_LIMIT_W-1:0];
                    default: ;
                endcase
            end

            if (reports.valid && reports.ready)
            begin
                got = '{reports.speed_out, reports.accel_out, reports.peak_speed,
                        reports.time_to_top_ms, reports.run_accel, reports.peak_accel,
                        reports.moving_time_ms, reports.is_moving};
                if (due_reports.size() == 0)
                begin
                    $error("report word with no report expected");
                    failures++;
                end
                else
                begin
                    want = due_reports.pop_front();
                    check_field("speed_out", $signed(want.speed_out), $signed(got.speed_out));
                    check_field("accel_out", $signed(want.accel_out), $signed(got.accel_out));
                    check_field("peak_speed", want.peak_speed, got.peak_speed);
                    check_field("time_to_top_ms", want.time_to_top_ms, got.time_to_top_ms);
                    check_field("run_accel", $signed(want.run_accel), $signed(got.run_accel));
                    check_field("peak_accel", want.peak_accel, got.peak_accel);
                    check_field("moving_time_ms", want.moving_time_ms, got.moving_time_ms);
                    check_field("is_moving", want.is_moving, got.is_moving);
                end
            end

            if (samples.valid && samples.ready)
            begin
                fires = track_sample('{samples.time_ms, samples.speed_sample,
                                       samples.angular_sample}, fresh);
                case (item_how)
                    EXP_ZERO_REPORT: due_reports.push_back('0);
                    EXP_SILENT: ;
                    default: if (fires) due_reports.push_back(fresh);
                endcase
            end
        end
    end

    // Report receiver: random stalls, one long hold-off once it has seen enough words.
    initial
    begin : report_sink
        int unsigned seen;
        int unsigned hold_left;
        bit held;
        seen = 0;
        hold_left = 0;
        held = 1'b0;
        reports.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && reports.valid && reports.ready)
                seen++;
            if (!held && seen == HOLD_AFTER)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                reports.ready <= 1'b0;
            end
            else
                reports.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Run limit.
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // Offers one sample word, after a random gap, and returns at the edge that takes it.
    task automatic send_sample(input sample_t smp, input exp_kind_t how);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            samples.valid <= 1'b0;
            @(posedge clk);
        end
        samples.valid          <= 1'b1;
        samples.time_ms        <= smp.time_ms;
        samples.speed_sample   <= smp.speed;
        samples.angular_sample <= smp.angular;
        item_how               <= how;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.addr  <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stops offering samples and waits until every expected report is in and the block is quiet.
    task automatic settle();
        samples.valid <= 1'b0;
        @(posedge clk);
        while (due_reports.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    function automatic step_row_t sample_row(input logic [TIME_W-1:0] t,
                                             input logic signed [SPEED_W-1:0] s,
                                             input logic signed [ANG_W-1:0] a,
                                             input exp_kind_t how);
        return '{ROW_SAMPLE, REG_NONE, '0, '{t, s, a}, how};
    endfunction

    function automatic step_row_t write_row(input logic [CFG_ADDR_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] val);
        return '{ROW_WRITE, idx, val, '0, EXP_PREDICT};
    endfunction

    // Stimulus.
    initial
    begin : stimulus
        step_row_t rows[$];
        logic [CFG_DATA_W-1:0] words[N_PHASES][4];
        cfg_t ph;
        logic [TIME_W-1:0] t_now;
        longint sp;
        longint an;
        longint lim;
        longint eps_l;
        int unsigned pick;
        sample_t smp;

        rst_n                  <= 1'b0;
        calm                   <= 1'b0;
        item_how               <= EXP_PREDICT;
        samples.valid          <= 1'b0;
        samples.time_ms        <= '0;
        samples.speed_sample   <= '0;
        samples.angular_sample <= '0;
        cfg.valid              <= 1'b0;
        cfg.addr               <= '0;
        cfg.data               <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: interval boundary, zero run times, extremes, time going backwards.
        rows.push_back(sample_row(32'd5, 24'sd0, 32'sd0, EXP_SILENT));
        rows.push_back(sample_row(32'd10, 24'sd0, 32'sd0, EXP_SILENT));
        rows.push_back(sample_row(32'd11, 24'sd0, 32'sd0, EXP_ZERO_REPORT));
        rows.push_back(write_row(REG_SPEED_EPSILON, 32'd0));
        rows.push_back(write_row(REG_STANDSTILL, 32'h007FFFFF));
        // New top speed while still at standstill: run time is zero, negative then positive.
        rows.push_back(sample_row(32'd30, -24'sd100, 32'sd0, EXP_PREDICT));
        rows.push_back(sample_row(32'd50, 24'sd200, 32'sd169, EXP_PREDICT));
        rows.push_back(write_row(REG_STANDSTILL, 32'd0));
        rows.push_back(write_row(REG_MOVING_LIMIT, 32'd0));
        rows.push_back(sample_row(32'd70, SPEED_MAX, 32'sd1, EXP_PREDICT));
        // Backwards timestamp with full negative speed: top speed saturates, times wrap.
        rows.push_back(sample_row(32'd20, SPEED_MIN, ANG_MIN, EXP_PREDICT));
        rows.push_back(write_row(REG_MOVING_LIMIT, 32'h7FFFFFFF));
        rows.push_back(write_row(REG_REPORT_INTERVAL, 32'd0));
        rows.push_back(sample_row(32'd21, SPEED_MAX, ANG_MAX, EXP_PREDICT));
        rows.push_back(sample_row(32'd22, SPEED_MIN, ANG_MIN, EXP_PREDICT));
        rows.push_back(sample_row(32'd22, 24'sd0, 32'sd0, EXP_SILENT));
        rows.push_back(write_row(REG_REPORT_INTERVAL, 32'h0000FFFF));
        rows.push_back(sample_row(32'd65557, 24'sd0, 32'sd0, EXP_SILENT));
        rows.push_back(sample_row(32'd65558, 24'sd0, 32'sd0, EXP_PREDICT));
        rows.push_back(sample_row(TIME_MAX, SPEED_MAX, ANG_MAX, EXP_PREDICT));
        rows.push_back(write_row(REG_NONE, 32'hFFFFFFFF));
        rows.push_back(sample_row(32'd0, SPEED_MIN, ANG_MIN, EXP_SILENT));

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_WRITE)
            begin
                settle();
                write_reg(rows[i].reg_idx, rows[i].reg_val);
            end
            else
                send_sample(rows[i].smp, rows[i].how);
        end

        // Register settings of the random phases: reset values, minima, maxima, mid, random.
        words[0] = '{32'd10, 32'd655, 32'd66, 32'd168};
        words[1] = '{32'd0, 32'd0, 32'd0, 32'd0};
        words[2] = '{32'h0000FFFF, 32'h007FFFFF, 32'h007FFFFF, 32'h7FFFFFFF};
        words[3] = '{32'd50, 32'd20000, 32'd3000, 32'h01000000};
        words[4] = '{($urandom() & 32'hFFFF0000) | $urandom_range(300),
                     ($urandom() & 32'hFF800000) | $urandom_range(16384),
                     ($urandom() & 32'hFF800000) | $urandom_range(16384),
                     ($urandom() & 32'h80000000) | $urandom_range(1 << 25)};

        t_now = 32'h00000100;
        sp = 0;
        for (int p = 0; p < N_PHASES; p++)
        begin
            ph.report_interval_ms = words[p][0][INTERVAL_W-1:0];
            ph.speed_epsilon      = words[p][1][SPEED_MAG_W-1:0];
            ph.standstill_limit   = words[p][2][SPEED_MAG_W-1:0];
            ph.moving_limit       = words[p][3][MOVE_LIMIT_W-1:0];
            settle();
            write_reg(REG_REPORT_INTERVAL, words[p][0]);
            write_reg(REG_SPEED_EPSILON, words[p][1]);
            write_reg(REG_STANDSTILL, words[p][2]);
            write_reg(REG_MOVING_LIMIT, words[p][3]);
            lim = longint'(ph.moving_limit);
            eps_l = longint'(ph.speed_epsilon);

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // One stretch runs with neither side idling.
                calm <= (p == 3) && (n < 200);

                // Timestamp: mostly past the interval, some inside it, a few jumps anywhere.
                pick = $urandom_range(99);
                if (pick < 5)
                    t_now = $urandom();
                else if (pick < 30)
                    t_now += $urandom_range(ph.report_interval_ms);
                else
                    t_now += ph.report_interval_ms + 1
                             + $urandom_range(ph.report_interval_ms / 4 + 20);

                // Speed: standstill, ramps, near the recorded top, extremes, noise.
                pick = $urandom_range(99);
                if (pick < 15)
                begin
                    sp = longint'($urandom_range(ph.standstill_limit));
                    if ($urandom_range(1))
                        sp = -sp;
                end
                else if (pick < 60)
                    sp += longint'($urandom_range(RAMP_STEP)) - RAMP_STEP / 4;
                else if (pick < 75)
                    sp = best_speed + longint'($urandom_range(2 * eps_l + 2)) - eps_l - 1;
                else if (pick < 85)
                    sp = ($urandom_range(1)) ? SPEED_HI : SPEED_LO;
                else
                    sp = $signed(SPEED_W'($urandom()));
                if (sp > SPEED_HI)
                    sp = SPEED_HI;
                if (sp < SPEED_LO)
                    sp = SPEED_LO;

                // Angular speed: below, at and above the moving limit, plus noise.
                pick = $urandom_range(99);
                if (pick < 30)
                    an = longint'($urandom_range(ph.moving_limit));
                else if (pick < 50)
                    an = lim + longint'($urandom_range(2)) - 1;
                else if (pick < 75)
                    an = lim + 1 + longint'($urandom_range(1 << 20));
                else
                    an = $signed($urandom());
                if (pick < 75 && $urandom_range(1))
                    an = -an;

                smp.time_ms = t_now;
                smp.speed   = sp[SPEED_W-1:0];
                smp.angular = an[ANG_W-1:0];
                send_sample(smp, EXP_PREDICT);
            end
        end

        settle();
        if (failures == 0 && due_reports.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
rtl/sst_pkg.sv
rtl/sst_if.sv
rtl/sst_cfg_regs.sv
rtl/sst_serial_div.sv
rtl/speed_statistics_tracker.sv
sim/speed_statistics_tracker_tb.sv
